### hw/rtl/lbct_pkg.sv
// ----------------------------------------------------------------------------
// lbct_pkg
// shared codes and fixed field widths of the block cache tag engine
// ----------------------------------------------------------------------------
package lbct_pkg;

	// fixed field widths
	localparam int OP_BITS   = 3;
	localparam int KIND_BITS = 2;
	localparam int SLOT_BITS = 6;
	localparam int BIU_BITS  = 7;

	// operation codes
	localparam logic [OP_BITS-1:0] OP_READ          = 3'd0;
	localparam logic [OP_BITS-1:0] OP_WRITE_THROUGH = 3'd1;
	localparam logic [OP_BITS-1:0] OP_WRITE_DEFER   = 3'd2;
	localparam logic [OP_BITS-1:0] OP_FLUSH_KEEP    = 3'd3;
	localparam logic [OP_BITS-1:0] OP_FLUSH_RELEASE = 3'd4;
	localparam logic [OP_BITS-1:0] OP_FLUSH_DISCARD = 3'd5;
	localparam logic [OP_BITS-1:0] OP_FLUSH_FORCE   = 3'd6;
	localparam logic [OP_BITS-1:0] OP_NONE          = 3'd7;

	// result kinds
	localparam logic [KIND_BITS-1:0] KIND_CACHED      = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_BYPASS      = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_FLUSH_WRITE = 2'd2;
	localparam logic [KIND_BITS-1:0] KIND_FLUSH_NONE  = 2'd3;

	// register indexes
	localparam logic REG_BLOCKS_IN_USE = 1'b0;
	localparam logic REG_KEEP_DISABLE  = 1'b1;

endpackage

### hw/rtl/lbct_if.sv
// ----------------------------------------------------------------------------
// lbct_in_if / lbct_out_if
// valid/ready channels carrying access words and result words
// ----------------------------------------------------------------------------
interface lbct_in_if #(
	parameter int FILE_ID_BITS   = 16,
	parameter int BLOCK_NUM_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic [lbct_pkg::OP_BITS-1:0]  op;
	logic [FILE_ID_BITS-1:0]       file_id;
	logic [BLOCK_NUM_BITS-1:0]     block_number;

	modport source (output valid, op, file_id, block_number, input ready);
	modport sink (input valid, op, file_id, block_number, output ready);
endinterface

interface lbct_out_if #(
	parameter int FILE_ID_BITS   = 16,
	parameter int BLOCK_NUM_BITS = 32
);
	logic                           valid;
	logic                           ready;
	logic [lbct_pkg::KIND_BITS-1:0] kind;
	logic                           hit;
	logic [lbct_pkg::SLOT_BITS-1:0] slot;
	logic                           fill_needed;
	logic                           write_needed;
	logic [FILE_ID_BITS-1:0]        write_file;
	logic [BLOCK_NUM_BITS-1:0]      write_block;
	logic                           last;

	modport source (output valid, kind, hit, slot, fill_needed, write_needed, write_file,
		write_block, last, input ready);
	modport sink (input valid, kind, hit, slot, fill_needed, write_needed, write_file,
		write_block, last, output ready);
endinterface

### hw/rtl/lru_block_cache_tags.sv
// ----------------------------------------------------------------------------
// lru_block_cache_tags
// tag and LRU policy engine of a fully associative write-back block cache
// ----------------------------------------------------------------------------
// Tags and recency ranks live in one single-port-read, one-port-write memory
// of NUM_SLOTS words; valid and dirty bits are flip-flops. Every pass over the
// cache streams the T taken slots through the memory, one slot per cycle, so
// T (slots taken, at most NUM_SLOTS) and result channel stalls set all timing.
// A miss into a free slot takes a lookup pass; a hit or an eviction takes a
// lookup pass, then a rank update pass. A flush other than discard with D dirty
// blocks of the file runs D+1 passes of the ordered writeback scan; release
// and discard add a rank update pass for each freed entry plus one final scan.
// A new word is taken only once the previous one has put its last result into
// the output register. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_block_cache_tags #(
	parameter int NUM_SLOTS      = 64,
	parameter int FILE_ID_BITS   = 16,
	parameter int BLOCK_NUM_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	lbct_in_if.sink     in_ch,
	lbct_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = $clog2(NUM_SLOTS);
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int MW = FILE_ID_BITS + BLOCK_NUM_BITS + IW;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_LOOK  = 9'b000000010,
		S_UPD   = 9'b000000100,
		S_AOUT  = 9'b000001000,
		S_FSCAN = 9'b000010000,
		S_FEMIT = 9'b000100000,
		S_FREE  = 9'b001000000,
		S_OLD   = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

	typedef struct packed {
		logic [lbct_pkg::KIND_BITS-1:0] kind;
		logic                           hit;
		logic [lbct_pkg::SLOT_BITS-1:0] slot;
		logic                           fill_needed;
		logic                           write_needed;
		logic [FILE_ID_BITS-1:0]        write_file;
		logic [BLOCK_NUM_BITS-1:0]      write_block;
		logic                           last;
	} res_t;

	// configuration
	logic [lbct_pkg::BIU_BITS-1:0] biu_q;
	logic                          kfd_q;
	logic [CW-1:0]                 limit;

	state_t state_q;

	// memory and scan pipeline
	logic [MW-1:0]             mem [NUM_SLOTS];
	logic [MW-1:0]             rd_word_s1;
	logic                      rd_v_s1;
	logic [IW-1:0]             idx_s1;
	logic [CW-1:0]             rd_cnt_q;
	logic                      issue, scanning, sweep_done;
	logic [FILE_ID_BITS-1:0]   rd_file;
	logic [BLOCK_NUM_BITS-1:0] rd_block;
	logic [IW-1:0]             rd_rank;
	logic                      wr_en;
	logic [IW-1:0]             wr_addr;
	logic [MW-1:0]             wr_word;
	logic [IW-1:0]             upd_rank;

	// cache state
	logic [NUM_SLOTS-1:0] valid_q, dirty_q;
	logic [CW-1:0]        taken_q;
	logic [CW-1:0]        taken_m1;

	// current word
	logic [lbct_pkg::OP_BITS-1:0] op_q;
	logic [FILE_ID_BITS-1:0]      file_q;
	logic [BLOCK_NUM_BITS-1:0]    block_q;

	// lookup and update bookkeeping
	logic                      found_q, newtag_q;
	logic [IW-1:0]             tgt_q, rank_q, vic_q;
	logic [FILE_ID_BITS-1:0]   vic_file_q;
	logic [BLOCK_NUM_BITS-1:0] vic_block_q;
	logic [CW-1:0]             free_ptr_q;

	// flush bookkeeping
	logic                      best_v_q, pend_v_q;
	logic [IW-1:0]             best_slot_q, pend_slot_q;
	logic [BLOCK_NUM_BITS-1:0] best_blk_q, pend_blk_q;

	// result staging and output register
	res_t res_q, out_q, load_val;
	logic out_v_q, can_load, load;
	logic in_acc, match_tag, miss_free;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == lbct_pkg::REG_KEEP_DISABLE) ? {31'd0, kfd_q}
		: {{(32 - lbct_pkg::BIU_BITS){1'b0}}, biu_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biu_q <= '0;
			kfd_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == lbct_pkg::REG_BLOCKS_IN_USE)
				biu_q <= pwdata[lbct_pkg::BIU_BITS-1:0];
			else
				kfd_q <= pwdata[0];
		end
	end

	// enabled slots clamp to the cache size
	always_comb begin
		if ({25'd0, biu_q} > 32'(NUM_SLOTS))
			limit = CW'(NUM_SLOTS);
		else
			limit = CW'(biu_q);
	end

	assign taken_m1 = taken_q - CW'(1);

	// scan engine
	assign scanning = (state_q == S_LOOK) || (state_q == S_UPD) || (state_q == S_FSCAN)
		|| (state_q == S_FREE) || (state_q == S_OLD);
	assign issue      = scanning && (rd_cnt_q < taken_q);
	assign sweep_done = !issue && !rd_v_s1;
	assign rd_file    = rd_word_s1[MW-1 -: FILE_ID_BITS];
	assign rd_block   = rd_word_s1[IW +: BLOCK_NUM_BITS];
	assign rd_rank    = rd_word_s1[IW-1:0];
	assign match_tag  = valid_q[idx_s1] && (rd_file == file_q) && (rd_block == block_q);
	assign miss_free  = !found_q && (taken_q < limit);

	// memory write: new slot fill or rank rewrite during a sweep
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = idx_s1;
		wr_word  = rd_word_s1;
		upd_rank = rd_rank;
		if (state_q == S_LOOK && sweep_done && miss_free) begin
			wr_en   = 1'b1;
			wr_addr = taken_q[IW-1:0];
			wr_word = {file_q, block_q, taken_q[IW-1:0]};
		end else if (state_q == S_UPD && rd_v_s1) begin
			wr_en = 1'b1;
			if (idx_s1 == tgt_q) begin
				upd_rank = taken_m1[IW-1:0];
				wr_word  = newtag_q ? {file_q, block_q, upd_rank}
					: {rd_file, rd_block, upd_rank};
			end else begin
				if (rd_rank > rank_q)
					upd_rank = rd_rank - IW'(1);
				wr_word = {rd_file, rd_block, upd_rank};
			end
		end else if (state_q == S_OLD && rd_v_s1) begin
			wr_en = 1'b1;
			if (idx_s1 == tgt_q)
				upd_rank = '0;
			else if (rd_rank < rank_q)
				upd_rank = rd_rank + IW'(1);
			wr_word = {rd_file, rd_block, upd_rank};
		end
	end

	always_ff @(posedge clk) begin
		if (issue)
			rd_word_s1 <= mem[rd_cnt_q[IW-1:0]];
		if (wr_en)
			mem[wr_addr] <= wr_word;
	end

	// output register
	assign can_load = !out_v_q || out_ch.ready;

	always_comb begin
		load     = 1'b0;
		load_val = res_q;
		case (state_q)
			S_AOUT: load = can_load;
			S_FEMIT: begin
				load     = can_load;
				load_val = '{lbct_pkg::KIND_FLUSH_WRITE, 1'b0,
					lbct_pkg::SLOT_BITS'(pend_slot_q), 1'b0, 1'b1, file_q, pend_blk_q, 1'b0};
			end
			S_FIN: begin
				load = can_load;
				if (pend_v_q)
					load_val = '{lbct_pkg::KIND_FLUSH_WRITE, 1'b0,
						lbct_pkg::SLOT_BITS'(pend_slot_q), 1'b0, 1'b1, file_q, pend_blk_q,
						1'b1};
				else
					load_val = '{lbct_pkg::KIND_FLUSH_NONE, 1'b0, '0, 1'b0, 1'b0, '0, '0,
						1'b1};
			end
			default: load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= load_val;
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.kind         = out_q.kind;
	assign out_ch.hit          = out_q.hit;
	assign out_ch.slot         = out_q.slot;
	assign out_ch.fill_needed  = out_q.fill_needed;
	assign out_ch.write_needed = out_q.write_needed;
	assign out_ch.write_file   = out_q.write_file;
	assign out_ch.write_block  = out_q.write_block;
	assign out_ch.last         = out_q.last;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && (state_q == S_IDLE);

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_cnt_q    <= '0;
			rd_v_s1     <= 1'b0;
			idx_s1      <= '0;
			valid_q     <= '0;
			dirty_q     <= '0;
			taken_q     <= '0;
			op_q        <= '0;
			file_q      <= '0;
			block_q     <= '0;
			found_q     <= 1'b0;
			newtag_q    <= 1'b0;
			tgt_q       <= '0;
			rank_q      <= '0;
			vic_q       <= '0;
			vic_file_q  <= '0;
			vic_block_q <= '0;
			free_ptr_q  <= '0;
			best_v_q    <= 1'b0;
			best_slot_q <= '0;
			best_blk_q  <= '0;
			pend_v_q    <= 1'b0;
			pend_slot_q <= '0;
			pend_blk_q  <= '0;
			res_q       <= '0;
		end else begin
			// default streaming of the scan pipeline
			rd_v_s1 <= issue;
			idx_s1  <= rd_cnt_q[IW-1:0];
			if (issue)
				rd_cnt_q <= rd_cnt_q + CW'(1);

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q     <= in_ch.op;
						file_q   <= in_ch.file_id;
						block_q  <= in_ch.block_number;
						rd_cnt_q <= '0;
						found_q  <= 1'b0;
						best_v_q <= 1'b0;
						pend_v_q <= 1'b0;
						free_ptr_q <= '0;
						if (in_ch.op inside {lbct_pkg::OP_READ, lbct_pkg::OP_WRITE_THROUGH,
							lbct_pkg::OP_WRITE_DEFER}) begin
							if (limit == '0) begin
								res_q <= '{lbct_pkg::KIND_BYPASS, 1'b0, '0, 1'b0, 1'b0,
									'0, '0, 1'b1};
								state_q <= S_AOUT;
							end else begin
								state_q <= S_LOOK;
							end
						end else if (in_ch.op != lbct_pkg::OP_NONE) begin
							if (limit == '0 || (kfd_q && in_ch.op == lbct_pkg::OP_FLUSH_KEEP))
								begin
								res_q <= '{lbct_pkg::KIND_FLUSH_NONE, 1'b0, '0, 1'b0, 1'b0,
									'0, '0, 1'b1};
								state_q <= S_AOUT;
							end else if (in_ch.op == lbct_pkg::OP_FLUSH_DISCARD) begin
								state_q <= S_FREE;
							end else begin
								state_q <= S_FSCAN;
							end
						end
					end
				end

				// associative lookup; also finds the least recent slot
				S_LOOK: begin
					if (rd_v_s1) begin
						if (match_tag && !found_q) begin
							found_q <= 1'b1;
							tgt_q   <= idx_s1;
							rank_q  <= rd_rank;
						end
						if (rd_rank == '0) begin
							vic_q       <= idx_s1;
							vic_file_q  <= rd_file;
							vic_block_q <= rd_block;
						end
					end
					if (sweep_done) begin
						rd_cnt_q <= '0;
						if (found_q) begin
							newtag_q <= 1'b0;
							if (op_q == lbct_pkg::OP_WRITE_THROUGH)
								dirty_q[tgt_q] <= 1'b0;
							else if (op_q == lbct_pkg::OP_WRITE_DEFER)
								dirty_q[tgt_q] <= 1'b1;
							res_q <= '{lbct_pkg::KIND_CACHED, 1'b1,
								lbct_pkg::SLOT_BITS'(tgt_q), 1'b0, 1'b0, '0, '0, 1'b1};
							state_q <= S_UPD;
						end else if (miss_free) begin
							taken_q <= taken_q + CW'(1);
							valid_q[taken_q[IW-1:0]] <= 1'b1;
							dirty_q[taken_q[IW-1:0]] <= (op_q == lbct_pkg::OP_WRITE_DEFER);
							res_q <= '{lbct_pkg::KIND_CACHED, 1'b0,
								lbct_pkg::SLOT_BITS'(taken_q),
								(op_q == lbct_pkg::OP_READ), 1'b0, '0, '0, 1'b1};
							state_q <= S_AOUT;
						end else begin
							newtag_q <= 1'b1;
							tgt_q    <= vic_q;
							rank_q   <= '0;
							valid_q[vic_q] <= 1'b1;
							dirty_q[vic_q] <= (op_q == lbct_pkg::OP_WRITE_DEFER);
							if (valid_q[vic_q] && dirty_q[vic_q])
								res_q <= '{lbct_pkg::KIND_CACHED, 1'b0,
									lbct_pkg::SLOT_BITS'(vic_q), (op_q == lbct_pkg::OP_READ),
									1'b1, vic_file_q, vic_block_q, 1'b1};
							else
								res_q <= '{lbct_pkg::KIND_CACHED, 1'b0,
									lbct_pkg::SLOT_BITS'(vic_q), (op_q == lbct_pkg::OP_READ),
									1'b0, '0, '0, 1'b1};
							state_q <= S_UPD;
						end
					end
				end

				// move target to most recent
				S_UPD: begin
					if (sweep_done)
						state_q <= S_AOUT;
				end

				S_AOUT: begin
					if (can_load)
						state_q <= S_IDLE;
				end

				// find lowest dirty block of the file
				S_FSCAN: begin
					if (rd_v_s1 && valid_q[idx_s1] && dirty_q[idx_s1] && rd_file == file_q
						&& (!best_v_q || rd_block < best_blk_q)) begin
						best_v_q    <= 1'b1;
						best_slot_q <= idx_s1;
						best_blk_q  <= rd_block;
					end
					if (sweep_done) begin
						rd_cnt_q <= '0;
						if (best_v_q) begin
							dirty_q[best_slot_q] <= 1'b0;
							if (pend_v_q) begin
								state_q <= S_FEMIT;
							end else begin
								pend_v_q    <= 1'b1;
								pend_slot_q <= best_slot_q;
								pend_blk_q  <= best_blk_q;
								best_v_q    <= 1'b0;
							end
						end else if (op_q == lbct_pkg::OP_FLUSH_RELEASE) begin
							state_q <= S_FREE;
						end else begin
							state_q <= S_FIN;
						end
					end
				end

				// send the held block, keep the new one back for the last mark
				S_FEMIT: begin
					if (can_load) begin
						pend_slot_q <= best_slot_q;
						pend_blk_q  <= best_blk_q;
						best_v_q    <= 1'b0;
						rd_cnt_q    <= '0;
						state_q     <= S_FSCAN;
					end
				end

				// next entry of the file to free, ascending slot order
				S_FREE: begin
					if (rd_v_s1 && valid_q[idx_s1] && rd_file == file_q) begin
						valid_q[idx_s1] <= 1'b0;
						dirty_q[idx_s1] <= 1'b0;
						tgt_q      <= idx_s1;
						rank_q     <= rd_rank;
						free_ptr_q <= CW'(idx_s1) + CW'(1);
						rd_cnt_q   <= '0;
						rd_v_s1    <= 1'b0;
						state_q    <= S_OLD;
					end else if (sweep_done) begin
						state_q <= S_FIN;
					end
				end

				// move freed entry to least recent
				S_OLD: begin
					if (sweep_done) begin
						rd_cnt_q <= free_ptr_q;
						state_q  <= S_FREE;
					end
				end

				S_FIN: begin
					if (can_load)
						state_q <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/lbct_chk.sv
// ----------------------------------------------------------------------------
// lbct_chk
// port-level checks of the block cache tag engine, bound to the top level
// ----------------------------------------------------------------------------
module lbct_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [lbct_pkg::OP_BITS-1:0]   in_op,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [lbct_pkg::KIND_BITS-1:0] out_kind,
	input logic                           out_hit,
	input logic                           out_write_needed,
	input logic                           out_last
);

	// a pending word is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// a real operation leaves the engine busy in the cycle after it is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op != lbct_pkg::OP_NONE |=> !in_ready)
		else $error("engine took a word while busy");

	// bypass and empty flush are single, write-free results
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == lbct_pkg::KIND_BYPASS
		|| out_kind == lbct_pkg::KIND_FLUSH_NONE) |-> out_last && !out_write_needed && !out_hit)
		else $error("bypass or empty flush result malformed");

	// flushed block always requests a write
	a_flush_wr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == lbct_pkg::KIND_FLUSH_WRITE |-> out_write_needed && !out_hit)
		else $error("flush block result without write");

endmodule

bind lru_block_cache_tags lbct_chk u_lbct_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.in_op            (in_ch.op),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_kind         (out_ch.kind),
	.out_hit          (out_ch.hit),
	.out_write_needed (out_ch.write_needed),
	.out_last         (out_ch.last)
);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the block cache tag engine: accesses and flushes go
// in through the word channel, an in-bench LRU tag model predicts every
// result word, and each result word is compared field by field in order
// ----------------------------------------------------------------------------
module tb_top;

	localparam int SLOTS      = 64;
	localparam int CYCLE_CAP  = 20000000;
	localparam int SETTLE     = 300;

	typedef struct packed {
		logic [lbct_pkg::KIND_BITS-1:0] kind;
		logic                           hit;
		logic [lbct_pkg::SLOT_BITS-1:0] slot;
		logic                           fill_needed;
		logic                           write_needed;
		logic [15:0]                    write_file;
		logic [31:0]                    write_block;
		logic                           last;
	} result_word_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	lbct_in_if  #(.FILE_ID_BITS(16), .BLOCK_NUM_BITS(32)) in_ch ();
	lbct_out_if #(.FILE_ID_BITS(16), .BLOCK_NUM_BITS(32)) out_ch ();

	lru_block_cache_tags #(.NUM_SLOTS(SLOTS), .FILE_ID_BITS(16), .BLOCK_NUM_BITS(32)) u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// clock
	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	// tag model state
	logic [15:0]     tag_file  [SLOTS];
	logic [31:0]     tag_block [SLOTS];
	bit              tag_valid [SLOTS];
	bit              tag_dirty [SLOTS];
	int              lru_rank  [SLOTS];
	int              slots_used;
	logic [6:0]      cfg_blocks;
	bit              cfg_keep_off;
	result_word_t    expected_words[$];
	bit              failed;
	int              hold_off;
	int              cycles;

	function automatic void promote(int s);
		int r;
		r = lru_rank[s];
		for (int t = 0; t < slots_used; t++)
			if (lru_rank[t] > r) lru_rank[t]--;
		lru_rank[s] = slots_used - 1;
	endfunction

	function automatic void demote(int s);
		int r;
		r = lru_rank[s];
		for (int t = 0; t < slots_used; t++)
			if (lru_rank[t] < r) lru_rank[t]++;
		lru_rank[s] = 0;
	endfunction

	function automatic result_word_t mk(logic [1:0] k, bit h, int s, bit fl, bit wn,
			logic [15:0] wf, logic [31:0] wb, bit lst);
		result_word_t w;
		w.kind = k; w.hit = h; w.slot = s[5:0]; w.fill_needed = fl;
		w.write_needed = wn; w.write_file = wf; w.write_block = wb; w.last = lst;
		return w;
	endfunction

	// predict the result words of one accepted word and update the tag model
	function automatic void predict_words(logic [2:0] op, logic [15:0] f, logic [31:0] b);
		int limit, s, n, best;
		bit found, any, wn;
		logic [15:0] wf;
		logic [31:0] wb;
		limit = (cfg_blocks > SLOTS) ? SLOTS : cfg_blocks;
		if (op == lbct_pkg::OP_NONE) return;
		if (op <= lbct_pkg::OP_WRITE_DEFER) begin
			if (limit == 0) begin
				expected_words.push_back(mk(lbct_pkg::KIND_BYPASS, 0, 0, 0, 0, 0, 0, 1));
				return;
			end
			found = 0; s = 0; wn = 0; wf = 0; wb = 0;
			for (int t = 0; t < slots_used; t++)
				if (!found && tag_valid[t] && tag_file[t] == f && tag_block[t] == b) begin
					s = t; found = 1;
				end
			if (found) begin
				promote(s);
			end else begin
				if (slots_used < limit) begin
					s = slots_used;
					slots_used++;
					lru_rank[s] = slots_used - 1;
				end else begin
					for (int t = slots_used - 1; t >= 0; t--)
						if (lru_rank[t] == 0) s = t;
					if (tag_valid[s] && tag_dirty[s]) begin
						wn = 1; wf = tag_file[s]; wb = tag_block[s];
					end
					promote(s);
				end
				tag_file[s] = f; tag_block[s] = b; tag_valid[s] = 1; tag_dirty[s] = 0;
			end
			if (op == lbct_pkg::OP_WRITE_THROUGH) tag_dirty[s] = 0;
			else if (op == lbct_pkg::OP_WRITE_DEFER) tag_dirty[s] = 1;
			expected_words.push_back(mk(lbct_pkg::KIND_CACHED, found, s,
				op == lbct_pkg::OP_READ && !found, wn, wf, wb, 1));
			return;
		end
		// flushes
		if (limit == 0 || (cfg_keep_off && op == lbct_pkg::OP_FLUSH_KEEP)) begin
			expected_words.push_back(mk(lbct_pkg::KIND_FLUSH_NONE, 0, 0, 0, 0, 0, 0, 1));
			return;
		end
		n = 0;
		if (op != lbct_pkg::OP_FLUSH_DISCARD) begin
			forever begin
				any = 0; best = 0;
				for (int t = 0; t < slots_used; t++)
					if (tag_valid[t] && tag_dirty[t] && tag_file[t] == f)
						if (!any || tag_block[t] < tag_block[best]) begin
							best = t; any = 1;
						end
				if (!any || n >= SLOTS) break;
				tag_dirty[best] = 0;
				expected_words.push_back(mk(lbct_pkg::KIND_FLUSH_WRITE, 0, best, 0, 1, f,
					tag_block[best], 0));
				n++;
			end
		end
		if (op == lbct_pkg::OP_FLUSH_RELEASE || op == lbct_pkg::OP_FLUSH_DISCARD)
			for (int t = 0; t < slots_used; t++)
				if (tag_valid[t] && tag_file[t] == f) begin
					tag_valid[t] = 0; tag_dirty[t] = 0;
					demote(t);
				end
		if (n == 0)
			expected_words.push_back(mk(lbct_pkg::KIND_FLUSH_NONE, 0, 0, 0, 0, 0, 0, 1));
		else
			expected_words[$].last = 1;
	endfunction

	// random gap: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// send one word, returning at the edge where it is taken
	task automatic send_word(logic [2:0] op, logic [15:0] f, logic [31:0] b, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.op           <= op;
		in_ch.file_id      <= f;
		in_ch.block_number <= b;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		predict_words(op, f, b);
	endtask

	// wait until every expected word has come, then let the block settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write, setup then access
	task automatic write_reg(logic idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == lbct_pkg::REG_BLOCKS_IN_USE) cfg_blocks = val[6:0];
		else cfg_keep_off = val[0];
	endtask

	// result side: random stalls, long hold-off on request, in-order check
	always @(posedge clk or negedge arst_n) begin : result_side
		int stall;
		bit nxt;
		result_word_t got, want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.kind, out_ch.hit, out_ch.slot, out_ch.fill_needed,
					out_ch.write_needed, out_ch.write_file, out_ch.write_block, out_ch.last};
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word, actual %p", $time, got);
					failed = 1;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch, expected %p, actual %p",
							$time, want, got);
						failed = 1;
					end
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				nxt = 1'b0;
			end else if (stall > 0) begin
				stall--;
				nxt = 1'b0;
			end else begin
				nxt = 1'b1;
				if ($urandom_range(0, 99) < 25) begin
					stall = pick_gap();
					nxt = (stall == 0);
				end
			end
			out_ch.ready <= nxt;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [15:0] rand_file();
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 3) * 16'h4001);
	endfunction

	function automatic logic [31:0] rand_block();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return $urandom_range(0, 11);
	endfunction

	function automatic logic [2:0] rand_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 76)
			return 3'($urandom_range(lbct_pkg::OP_READ, lbct_pkg::OP_WRITE_DEFER));
		if (r < 96)
			return 3'($urandom_range(lbct_pkg::OP_FLUSH_KEEP, lbct_pkg::OP_FLUSH_FORCE));
		return lbct_pkg::OP_NONE;
	endfunction

	// no cache: accesses bypass, flushes write nothing
	task automatic test_bypass();
		write_reg(lbct_pkg::REG_BLOCKS_IN_USE, 0);
		write_reg(lbct_pkg::REG_KEEP_DISABLE, 0);
		send_word(lbct_pkg::OP_READ, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(lbct_pkg::OP_WRITE_DEFER, 16'h0000, 32'h0);
		send_word(lbct_pkg::OP_FLUSH_FORCE, 16'h0000, 32'h0);
		send_word(lbct_pkg::OP_NONE, 16'h1234, 32'h5);
		drain();
	endtask

	// field extremes, every op, hits, dirty flush order, keep-flush disable
	task automatic test_ops_directed();
		write_reg(lbct_pkg::REG_BLOCKS_IN_USE, SLOTS);
		send_word(lbct_pkg::OP_READ, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(lbct_pkg::OP_READ, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(lbct_pkg::OP_WRITE_DEFER, 16'hFFFF, 32'h0000_0007);
		send_word(lbct_pkg::OP_WRITE_DEFER, 16'hFFFF, 32'h0000_0002);
		send_word(lbct_pkg::OP_WRITE_THROUGH, 16'h0000, 32'h0);
		send_word(lbct_pkg::OP_WRITE_DEFER, 16'h0000, 32'h0);
		send_word(lbct_pkg::OP_READ, 16'h0000, 32'h0);
		send_word(lbct_pkg::OP_FLUSH_KEEP, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(lbct_pkg::OP_FLUSH_KEEP, 16'hFFFF, 32'h0);
		send_word(lbct_pkg::OP_WRITE_DEFER, 16'hFFFF, 32'h0000_0009);
		send_word(lbct_pkg::OP_FLUSH_RELEASE, 16'hFFFF, 32'h0);
		send_word(lbct_pkg::OP_FLUSH_DISCARD, 16'h0000, 32'h0);
		send_word(lbct_pkg::OP_READ, 16'h0000, 32'h1);
		send_word(lbct_pkg::OP_FLUSH_FORCE, 16'h0000, 32'h0);
		send_word(lbct_pkg::OP_NONE, 16'hFFFF, 32'hFFFF_FFFF);
		drain();
		write_reg(lbct_pkg::REG_KEEP_DISABLE, 1);
		send_word(lbct_pkg::OP_WRITE_DEFER, 16'h0005, 32'h3);
		send_word(lbct_pkg::OP_FLUSH_KEEP, 16'h0005, 32'h0);
		send_word(lbct_pkg::OP_FLUSH_FORCE, 16'h0005, 32'h0);
		drain();
		write_reg(lbct_pkg::REG_KEEP_DISABLE, 0);
	endtask

	// tiny cache: dirty victims, then shrink below the taken slots
	task automatic test_eviction();
		write_reg(lbct_pkg::REG_BLOCKS_IN_USE, 2);
		send_word(lbct_pkg::OP_WRITE_DEFER, 16'h0001, 32'h10);
		send_word(lbct_pkg::OP_WRITE_DEFER, 16'h0001, 32'h11);
		send_word(lbct_pkg::OP_READ, 16'h0001, 32'h10);
		send_word(lbct_pkg::OP_READ, 16'h0002, 32'h20);
		send_word(lbct_pkg::OP_WRITE_THROUGH, 16'h0002, 32'h21);
		drain();
		write_reg(lbct_pkg::REG_BLOCKS_IN_USE, 1);
		send_word(lbct_pkg::OP_WRITE_DEFER, 16'h0003, 32'h30);
		send_word(lbct_pkg::OP_READ, 16'h0003, 32'h31);
		drain();
	endtask

	// random words over several cache sizes
	task automatic test_random(int count, logic [6:0] blocks, bit keep_off);
		write_reg(lbct_pkg::REG_BLOCKS_IN_USE, 32'(blocks));
		write_reg(lbct_pkg::REG_KEEP_DISABLE, 32'(keep_off));
		for (int i = 0; i < count; i++)
			send_word(rand_op(), rand_file(), rand_block(), i % 40 < 8);
		drain();
	endtask

	// long result hold-off while words keep coming, then pause until empty
	task automatic test_backpressure();
		write_reg(lbct_pkg::REG_BLOCKS_IN_USE, 8);
		hold_off = 500;
		for (int i = 0; i < 20; i++)
			send_word(rand_op(), rand_file(), rand_block(), 1);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		failed = 0; hold_off = 0; cycles = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_ch.valid = 0; in_ch.op = lbct_pkg::OP_NONE; in_ch.file_id = 0;
		in_ch.block_number = 0;
		slots_used = 0; cfg_blocks = 0; cfg_keep_off = 0;
		for (int t = 0; t < SLOTS; t++) begin
			tag_valid[t] = 0; tag_dirty[t] = 0; lru_rank[t] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bypass();
		test_ops_directed();
		test_eviction();
		test_random(50, 7'd64, 0);
		test_random(30, 7'd8, 1);
		test_random(25, 7'd3, 0);
		test_random(40, 7'd127, 0);
		test_random(12, 7'd0, 0);
		test_random(14, 7'd5, 0);
		test_backpressure();
		if (!failed)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

### lru_block_cache_tags.f
hw/rtl/lbct_pkg.sv
hw/rtl/lbct_if.sv
hw/rtl/lru_block_cache_tags.sv
hw/rtl/lbct_chk.sv
bench/tb_top.sv
